>>> hw/rtl/qkvud_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkvud_pkg
// shared types and constants of the query key value url decode core
// ----------------------------------------------------------------------------
package qkvud_pkg;

	localparam int KEY_MAX   = 16;
	localparam int KEY_W     = 8 * KEY_MAX;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int MAX_WORDS = 4;

	// register indexes on the configuration port
	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_KEY_LEN  = 2'd2;
	localparam logic [1:0] REG_OUT_LIM  = 2'd3;

	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_PCT   = 8'h25;
	localparam logic [7:0] CHR_AMP   = 8'h26;
	localparam logic [7:0] CHR_EQ    = 8'h3D;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [4:0]       key_length;
		logic [7:0]       out_limit;
	} cfg_t;

	// one result word
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] value_byte;
		logic [7:0] value_length;
		logic       last;
	} word_t;

	// all result words caused by one query byte
	typedef struct packed {
		logic [2:0]                 cnt;
		word_t [MAX_WORDS-1:0]      w;
	} bundle_t;

	typedef struct packed {
		logic              full;
		logic              valid;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage
`default_nettype wire

>>> hw/rtl/query_key_value_url_decode_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// query_key_value_url_decode_core
// finds one query parameter by key and streams out its url-decoded value
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// config    in/out     psel penable pwrite    paddr pwdata prdata (64 bit)
// query     in         push / full            query_byte is_end
// result    out        empty / pop            byte_valid value_byte
//                                             value_length last
//
// one query byte is taken per cycle while full is low; the scanner decides all result words of
// that byte in the cycle it is accepted (zero to four words)
// result words leave at one per cycle while pop is high, so the output port sets the rate when
// bytes make more than one word each
// a four-bundle queue parts scanner and serialiser: full rises only when four
// bundles wait behind the one being handed out
// first word passes a queue slot and then the serialiser's bundle register
// reset clears scanner state, queue pointers and registers to reset values
// ----------------------------------------------------------------------------
module query_key_value_url_decode_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	// query bytes
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  query_byte,
	input  wire logic        is_end,
	// result words
	output logic             empty,
	input  wire logic        pop,
	output logic             byte_valid,
	output logic      [7:0]  value_byte,
	output logic      [7:0]  value_length,
	output logic             last
);
	import qkvud_pkg::*;

	// configuration registers
	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  key_len_q;
	logic [7:0]  out_lim_q;

	logic        cfg_wr;
	logic [1:0]  reg_idx;
	cfg_t        cfg;

	bundle_t     fr_bundle;
	logic        fr_valid;
	bundle_t     q_data;
	qstat_t      q_stat;
	logic        q_rd;
	logic        accept;
	word_t       word;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	// registers sit on 8-byte steps
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= 64'd0;
			key_high_q <= 64'd0;
			key_len_q  <= 5'd0;
			out_lim_q  <= 8'd255;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LEN:  key_len_q  <= pwdata[4:0];
				REG_OUT_LIM:  out_lim_q  <= pwdata[7:0];
				default:      key_low_q  <= key_low_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LEN:  prdata = {59'd0, key_len_q};
			REG_OUT_LIM:  prdata = {56'd0, out_lim_q};
			default:      prdata = 64'd0;
		endcase
	end

	assign cfg.key        = {key_high_q, key_low_q};
	assign cfg.key_length = key_len_q;
	assign cfg.out_limit  = out_lim_q;

	// a byte is taken whenever the queue has room for its bundle
	assign full   = q_stat.full;
	assign accept = push && !full;

	qkvud_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.query_byte   (query_byte),
		.is_end       (is_end),
		.bundle       (fr_bundle),
		.bundle_valid (fr_valid)
	);

	// bytes that make no word leave nothing in the queue
	qkvud_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid),
		.wr_data (fr_bundle),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.stat    (q_stat)
	);

	qkvud_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_valid (q_stat.valid),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.word    (word)
	);

	assign byte_valid   = word.byte_valid;
	assign value_byte   = word.value_byte;
	assign value_length = word.value_length;
	assign last         = word.last;

	// final word carries only the length
	a_final_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (!byte_valid && value_byte == 8'd0))
		else $error("final word carries a data byte");

	// data words carry no length and no end mark
	a_data_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && byte_valid) |-> (!last && value_length == 8'd0))
		else $error("data word carries length or end mark");

	// a bundle is only written into a queue with room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid |-> !q_stat.full)
		else $error("bundle written into a full queue");

	// pushed bundles hold one to four words
	a_bundle_size: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid |-> (fr_bundle.cnt != 3'd0 && fr_bundle.cnt <= 3'd4))
		else $error("bundle word count out of range");

endmodule
`default_nettype wire

>>> hw/rtl/qkvud_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkvud_front
// scanner: key matching, escape tracking and result bundle building
// ----------------------------------------------------------------------------
module qkvud_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qkvud_pkg::cfg_t    cfg,
	input  wire logic               accept,
	input  wire logic [7:0]         query_byte,
	input  wire logic               is_end,
	output qkvud_pkg::bundle_t      bundle,
	output logic                    bundle_valid
);
	import qkvud_pkg::*;

	localparam logic [1:0] PH_MATCH = 2'd0;
	localparam logic [1:0] PH_SKIP  = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_HEX  = 2'd2;

	typedef struct packed {
		logic [1:0]            phase;
		logic [1:0]            esc;
		logic [7:0]            cnt;
		logic [2:0]            n;
		word_t [MAX_WORDS-1:0] w;
	} work_t;

	logic [1:0] phase_q;
	logic [4:0] key_pos_q;
	logic [1:0] esc_q;
	logic [7:0] held_q;
	logic [7:0] cnt_q;

	work_t      wk;
	logic [4:0] pos_n;
	logic [7:0] held_n;
	logic       end_b;
	logic [4:0] klen;
	logic [7:0] key_b;
	logic [4:0] hex_b;
	logic [4:0] hex_h;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
		return v;
	endfunction

	function automatic work_t emit_final(input work_t w);
		work_t r;
		r = w;
		if (!r.n[2]) begin
			r.w[r.n[1:0]] = '{byte_valid: 1'b0, value_byte: 8'd0,
				value_length: r.cnt, last: 1'b1};
			r.n = r.n + 3'd1;
		end
		r.phase = PH_DONE;
		r.esc   = ESC_NONE;
		return r;
	endfunction

	function automatic work_t emit_data(input work_t w, input logic [7:0] b,
		input logic [7:0] limit);
		work_t r;
		r = w;
		if (r.phase == PH_VALUE) begin
			if (!r.n[2]) begin
				r.w[r.n[1:0]] = '{byte_valid: 1'b1, value_byte: b,
					value_length: 8'd0, last: 1'b0};
				r.n = r.n + 3'd1;
			end
			r.cnt = r.cnt + 8'd1;
			if (r.cnt >= limit) r = emit_final(r);
		end
		return r;
	endfunction

	function automatic work_t plain_byte(input work_t w, input logic [7:0] b,
		input logic [7:0] limit);
		work_t r;
		r = w;
		if (r.phase == PH_VALUE) begin
			if (b == CHR_AMP) r = emit_final(r);
			else if (b == CHR_PLUS) r = emit_data(r, CHR_SPACE, limit);
			else if (b == CHR_PCT) r.esc = ESC_PCT;
			else r = emit_data(r, b, limit);
		end
		return r;
	endfunction

	assign klen  = (cfg.key_length > 5'(KEY_MAX)) ? 5'(KEY_MAX) : cfg.key_length;
	assign key_b = cfg.key[{key_pos_q[3:0], 3'd0} +: 8];
	assign end_b = is_end || (query_byte == 8'd0);
	assign hex_b = hex_val(query_byte);
	assign hex_h = hex_val(held_q);

	always_comb begin
		wk       = '0;
		wk.phase = phase_q;
		wk.esc   = esc_q;
		wk.cnt   = cnt_q;
		pos_n    = key_pos_q;
		held_n   = held_q;
		if (end_b) begin
			if (phase_q == PH_VALUE) begin
				wk.esc = ESC_NONE;
				if (esc_q != ESC_NONE) wk = emit_data(wk, CHR_PCT, cfg.out_limit);
				if (esc_q == ESC_HEX) wk = plain_byte(wk, held_q, cfg.out_limit);
			end
			if (wk.phase != PH_DONE) wk = emit_final(wk);
			wk.phase = PH_MATCH;
			wk.esc   = ESC_NONE;
			wk.cnt   = 8'd0;
			pos_n    = 5'd0;
			held_n   = 8'd0;
		end else begin
			unique case (phase_q)
				PH_MATCH: begin
					if (query_byte == CHR_AMP) begin
						pos_n = 5'd0;
					end else if (key_pos_q < klen) begin
						if (query_byte == key_b) pos_n = key_pos_q + 5'd1;
						else wk.phase = PH_SKIP;
					end else if (query_byte == CHR_EQ) begin
						wk.phase = PH_VALUE;
						wk.cnt   = 8'd0;
						wk.esc   = ESC_NONE;
						if (cfg.out_limit == 8'd0) wk = emit_final(wk);
					end else begin
						wk.phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (query_byte == CHR_AMP) begin
						wk.phase = PH_MATCH;
						pos_n    = 5'd0;
					end
				end
				PH_VALUE: begin
					if (esc_q == ESC_NONE) begin
						wk = plain_byte(wk, query_byte, cfg.out_limit);
					end else if (esc_q == ESC_PCT) begin
						if (!hex_b[4]) begin
							held_n = query_byte;
							wk.esc = ESC_HEX;
						end else begin
							wk.esc = ESC_NONE;
							wk = emit_data(wk, CHR_PCT, cfg.out_limit);
							wk = plain_byte(wk, query_byte, cfg.out_limit);
						end
					end else begin
						wk.esc = ESC_NONE;
						if (!hex_b[4]) begin
							wk = emit_data(wk, {hex_h[3:0], hex_b[3:0]}, cfg.out_limit);
						end else begin
							wk = emit_data(wk, CHR_PCT, cfg.out_limit);
							wk = plain_byte(wk, held_q, cfg.out_limit);
							wk = plain_byte(wk, query_byte, cfg.out_limit);
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MATCH;
			key_pos_q <= 5'd0;
			esc_q     <= ESC_NONE;
			held_q    <= 8'd0;
			cnt_q     <= 8'd0;
		end else if (accept) begin
			phase_q   <= wk.phase;
			key_pos_q <= pos_n;
			esc_q     <= wk.esc;
			held_q    <= held_n;
			cnt_q     <= wk.cnt;
		end
	end

	assign bundle.cnt   = wk.n;
	assign bundle.w     = wk.w;
	assign bundle_valid = accept && (wk.n != 3'd0);

endmodule
`default_nettype wire

>>> hw/rtl/qkvud_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkvud_queue
// short bundle queue between scanner and output serialiser
// ----------------------------------------------------------------------------
module qkvud_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire qkvud_pkg::bundle_t wr_data,
	input  wire logic               rd_en,
	output qkvud_pkg::bundle_t      rd_data,
	output qkvud_pkg::qstat_t       stat
);
	import qkvud_pkg::*;

	bundle_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr_en && !rd_en) count_q <= count_q + QCNT_W'(1);
			else if (rd_en && !wr_en) count_q <= count_q - QCNT_W'(1);
		end
	end

	assign rd_data    = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.valid = (count_q != '0);
	assign stat.count = count_q;

endmodule
`default_nettype wire

>>> hw/rtl/qkvud_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qkvud_back
// output serialiser: hands out the words of one bundle, one per pop
// ----------------------------------------------------------------------------
module qkvud_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qkvud_pkg::bundle_t q_data,
	input  wire logic               q_valid,
	output logic                    q_rd,
	input  wire logic               pop,
	output logic                    empty,
	output qkvud_pkg::word_t        word
);
	import qkvud_pkg::*;

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       cur_valid_q;
	logic       last_of;
	logic       take;

	assign last_of = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;
	assign take    = pop && cur_valid_q;
	assign q_rd    = q_valid && (!cur_valid_q || (take && last_of));

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (q_rd) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (take) begin
			if (last_of) cur_valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	assign empty = !cur_valid_q;
	assign word  = cur_q.w[idx_q];

endmodule
`default_nettype wire
